/* rtl/thr_hyst_pkg.sv */
// ----------------------------------------------------------------------------
// thr_hyst_pkg
// Types, register map and reset values of the thermal threshold block.
// ----------------------------------------------------------------------------
package thr_hyst_pkg;

	localparam int FACE_SENSORS_DEF = 8;
	localparam int CELL_SENSORS_DEF = 4;

	// APB register map, byte address 4*index
	localparam int CFG_ADDR_W = 5;
	localparam logic [2:0] REG_FACE_LOWER = 3'd0;
	localparam logic [2:0] REG_FACE_UPPER = 3'd1;
	localparam logic [2:0] REG_CELL_LOWER = 3'd2;
	localparam logic [2:0] REG_CELL_UPPER = 3'd3;
	localparam logic [2:0] REG_MARGIN     = 3'd4;

	localparam logic signed [15:0] FACE_LOWER_RST = -16'sd320;
	localparam logic signed [15:0] FACE_UPPER_RST = 16'sd960;
	localparam logic signed [15:0] CELL_LOWER_RST = 16'sd0;
	localparam logic signed [15:0] CELL_UPPER_RST = 16'sd720;
	localparam logic [11:0]        MARGIN_RST     = 12'd32;

	typedef enum logic [1:0] {
		EV_NONE  = 2'd0,
		EV_BELOW = 2'd1,
		EV_ABOVE = 2'd2
	} event_t;

	typedef struct packed {
		logic hot;
		logic cold;
	} flags_t;

	typedef struct packed {
		logic signed [15:0] face_lower;
		logic signed [15:0] face_upper;
		logic signed [15:0] cell_lower;
		logic signed [15:0] cell_upper;
		logic [11:0]        margin;
	} cfg_t;

endpackage

/* rtl/thr_hyst_if.sv */
// ----------------------------------------------------------------------------
// thr_hyst_if
// Valid/ready channels for sensor readings and comparator results.
// ----------------------------------------------------------------------------
interface thr_hyst_sensor_if;
	logic               valid;
	logic               ready;
	logic               sensor_class;
	logic [2:0]         sensor_index;
	logic signed [15:0] reading;
	logic               read_ok;

	modport source (output valid, sensor_class, sensor_index, reading, read_ok, input ready);
	modport sink (input valid, sensor_class, sensor_index, reading, read_ok, output ready);
endinterface

interface thr_hyst_result_if;
	logic       valid;
	logic       ready;
	logic [1:0] event_code;
	logic       hot_active;
	logic       cold_active;
	logic       rejected;

	modport source (output valid, event_code, hot_active, cold_active, rejected, input ready);
	modport sink (input valid, event_code, hot_active, cold_active, rejected, output ready);
endinterface

/* rtl/thr_hyst_ram.sv */
// ----------------------------------------------------------------------------
// thr_hyst_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module thr_hyst_ram #(
	parameter int WIDTH = 2,
	parameter int DEPTH = 8,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

/* rtl/thr_hyst_cfg.sv */
// ----------------------------------------------------------------------------
// thr_hyst_cfg
// APB register file holding the thresholds and the release margin.
// ----------------------------------------------------------------------------
module thr_hyst_cfg (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [thr_hyst_pkg::CFG_ADDR_W-1:0] paddr,
	input  logic [31:0]                       pwdata,
	output logic [31:0]                       prdata,
	output logic                              pready,
	output thr_hyst_pkg::cfg_t                cfg
);
	import thr_hyst_pkg::*;

	cfg_t       cfg_q;
	logic       wr_en;
	logic [2:0] reg_sel;

	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite & pready;
	assign reg_sel = paddr[4:2];
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.face_lower <= FACE_LOWER_RST;
			cfg_q.face_upper <= FACE_UPPER_RST;
			cfg_q.cell_lower <= CELL_LOWER_RST;
			cfg_q.cell_upper <= CELL_UPPER_RST;
			cfg_q.margin     <= MARGIN_RST;
		end else if (wr_en) begin
			case (reg_sel)
				REG_FACE_LOWER: cfg_q.face_lower <= pwdata[15:0];
				REG_FACE_UPPER: cfg_q.face_upper <= pwdata[15:0];
				REG_CELL_LOWER: cfg_q.cell_lower <= pwdata[15:0];
				REG_CELL_UPPER: cfg_q.cell_upper <= pwdata[15:0];
				REG_MARGIN:     cfg_q.margin     <= pwdata[11:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_sel)
			REG_FACE_LOWER: prdata = {{16{cfg_q.face_lower[15]}}, cfg_q.face_lower};
			REG_FACE_UPPER: prdata = {{16{cfg_q.face_upper[15]}}, cfg_q.face_upper};
			REG_CELL_LOWER: prdata = {{16{cfg_q.cell_lower[15]}}, cfg_q.cell_lower};
			REG_CELL_UPPER: prdata = {{16{cfg_q.cell_upper[15]}}, cfg_q.cell_upper};
			REG_MARGIN:     prdata = {20'd0, cfg_q.margin};
			default:        prdata = 32'd0;
		endcase
	end

endmodule

/* rtl/thermal_threshold_hysteresis_top.sv */
// ----------------------------------------------------------------------------
// thermal_threshold_hysteresis_top
// Per-sensor hot/cold hysteresis comparator for face and battery cell sensors.
// ----------------------------------------------------------------------------
// One reading is taken every clock cycle unless the result channel stalls. A
// reading is accepted, its sensor's flag pair is read from the class RAM as
// the reading enters stage 1, compared there and written back when stage 1
// advances, which also loads the result into the output register. The
// throughput of one reading per cycle, unless the result channel stalls, is
// set by the single read-modify-write pass over each flag RAM; a write-back
// register forwards the pair just written to a following reading of the same
// sensor. The flag RAMs need no clearing pass: a valid bit per sensor makes an
// unwritten entry read as both flags clear from reset on. Readings with a
// failed read or an index beyond the sensor count of their class leave the
// flags alone and come back marked rejected.
module thermal_threshold_hysteresis_top #(
	parameter int FACE_SENSORS = thr_hyst_pkg::FACE_SENSORS_DEF,
	parameter int CELL_SENSORS = thr_hyst_pkg::CELL_SENSORS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	thr_hyst_sensor_if.sink                     sensor,
	thr_hyst_result_if.source                   result,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [thr_hyst_pkg::CFG_ADDR_W-1:0] paddr,
	input  logic [31:0]                         pwdata,
	output logic [31:0]                         prdata,
	output logic                                pready
);
	import thr_hyst_pkg::*;

	localparam int FACE_AW = (FACE_SENSORS > 1) ? $clog2(FACE_SENSORS) : 1;
	localparam int CELL_AW = (CELL_SENSORS > 1) ? $clog2(CELL_SENSORS) : 1;
	localparam logic [3:0] FACE_CNT = 4'(FACE_SENSORS);
	localparam logic [3:0] CELL_CNT = 4'(CELL_SENSORS);

	cfg_t cfg;

	thr_hyst_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// ---------------------------------------------------------------- accept
	logic accept;
	logic advance;
	logic in_range;
	logic face_re;
	logic cell_re;

	assign accept   = sensor.valid & sensor.ready;
	assign in_range = sensor.sensor_class ? ({1'b0, sensor.sensor_index} < CELL_CNT)
	                                      : ({1'b0, sensor.sensor_index} < FACE_CNT);
	assign face_re  = accept & ~sensor.sensor_class & in_range;
	assign cell_re  = accept & sensor.sensor_class & in_range;

	// ---------------------------------------------------------------- stage 1
	logic               valid_s1;
	logic               class_s1;
	logic [2:0]         index_s1;
	logic signed [15:0] reading_s1;
	logic               read_ok_s1;
	logic               in_range_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (sensor.ready) begin
			valid_s1 <= sensor.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			class_s1    <= sensor.sensor_class;
			index_s1    <= sensor.sensor_index;
			reading_s1  <= sensor.reading;
			read_ok_s1  <= sensor.read_ok;
			in_range_s1 <= in_range;
		end
	end

	assign sensor.ready = ~valid_s1 | advance;

	// flag RAMs with per-entry valid bits
	logic [FACE_AW-1:0]      face_addr_s1;
	logic [CELL_AW-1:0]      cell_addr_s1;
	flags_t                  face_rd;
	flags_t                  cell_rd;
	logic [FACE_SENSORS-1:0] face_valid_q;
	logic [CELL_SENSORS-1:0] cell_valid_q;
	logic                    wr_en;
	logic                    face_we;
	logic                    cell_we;
	flags_t                  new_flags;

	assign face_addr_s1 = index_s1[FACE_AW-1:0];
	assign cell_addr_s1 = index_s1[CELL_AW-1:0];
	assign wr_en        = valid_s1 & advance & in_range_s1 & read_ok_s1;
	assign face_we      = wr_en & ~class_s1;
	assign cell_we      = wr_en & class_s1;

	thr_hyst_ram #(.WIDTH($bits(flags_t)), .DEPTH(FACE_SENSORS)) u_face_ram (
		.clk   (clk),
		.we    (face_we),
		.waddr (face_addr_s1),
		.wdata (new_flags),
		.re    (face_re),
		.raddr (sensor.sensor_index[FACE_AW-1:0]),
		.rdata (face_rd)
	);

	thr_hyst_ram #(.WIDTH($bits(flags_t)), .DEPTH(CELL_SENSORS)) u_cell_ram (
		.clk   (clk),
		.we    (cell_we),
		.waddr (cell_addr_s1),
		.wdata (new_flags),
		.re    (cell_re),
		.raddr (sensor.sensor_index[CELL_AW-1:0]),
		.rdata (cell_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			face_valid_q <= '0;
			cell_valid_q <= '0;
		end else begin
			if (face_we) begin
				face_valid_q[face_addr_s1] <= 1'b1;
			end
			if (cell_we) begin
				cell_valid_q[cell_addr_s1] <= 1'b1;
			end
		end
	end

	// last write-back, covers a read issued on the same edge as the write
	logic       fwd_valid_q;
	logic       fwd_class_q;
	logic [2:0] fwd_index_q;
	flags_t     fwd_flags_q;
	logic       fwd_hit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_valid_q <= 1'b0;
		end else if (wr_en) begin
			fwd_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			fwd_class_q <= class_s1;
			fwd_index_q <= index_s1;
			fwd_flags_q <= new_flags;
		end
	end

	assign fwd_hit = fwd_valid_q & (fwd_class_q == class_s1) & (fwd_index_q == index_s1);

	// compare and update
	flags_t             cur_flags;
	logic signed [17:0] rd_w;
	logic signed [17:0] lower_w;
	logic signed [17:0] upper_w;
	logic signed [17:0] lower_rel;
	logic signed [17:0] upper_rel;
	logic signed [17:0] margin_w;
	event_t             event_s1;
	logic               rejected_s1;
	flags_t             out_flags;

	always_comb begin
		if (fwd_hit) begin
			cur_flags = fwd_flags_q;
		end else if (class_s1) begin
			cur_flags = cell_valid_q[cell_addr_s1] ? cell_rd : '0;
		end else begin
			cur_flags = face_valid_q[face_addr_s1] ? face_rd : '0;
		end

		rd_w      = {{2{reading_s1[15]}}, reading_s1};
		lower_w   = class_s1 ? {{2{cfg.cell_lower[15]}}, cfg.cell_lower}
		                     : {{2{cfg.face_lower[15]}}, cfg.face_lower};
		upper_w   = class_s1 ? {{2{cfg.cell_upper[15]}}, cfg.cell_upper}
		                     : {{2{cfg.face_upper[15]}}, cfg.face_upper};
		margin_w  = {6'd0, cfg.margin};
		lower_rel = lower_w + margin_w;
		upper_rel = upper_w - margin_w;

		new_flags = cur_flags;
		event_s1  = EV_NONE;
		if (!cur_flags.cold && (rd_w < lower_w)) begin
			new_flags.cold = 1'b1;
			new_flags.hot  = 1'b0;
			event_s1       = EV_BELOW;
		end else begin
			if (rd_w > lower_rel) begin
				new_flags.cold = 1'b0;
			end
			if (!cur_flags.hot && (rd_w > upper_w)) begin
				new_flags.hot  = 1'b1;
				new_flags.cold = 1'b0;
				event_s1       = EV_ABOVE;
			end else if (rd_w < upper_rel) begin
				new_flags.hot = 1'b0;
			end
		end

		if (!in_range_s1) begin
			out_flags   = '0;
			event_s1    = EV_NONE;
			rejected_s1 = 1'b1;
		end else if (!read_ok_s1) begin
			out_flags   = cur_flags;
			event_s1    = EV_NONE;
			rejected_s1 = 1'b1;
		end else begin
			out_flags   = new_flags;
			rejected_s1 = 1'b0;
		end
	end

	// ---------------------------------------------------------------- output
	logic   out_valid_q;
	event_t event_q;
	flags_t flags_q;
	logic   rejected_q;

	assign advance = ~out_valid_q | result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance & valid_s1) begin
			event_q    <= event_s1;
			flags_q    <= out_flags;
			rejected_q <= rejected_s1;
		end
	end

	assign result.valid       = out_valid_q;
	assign result.event_code  = event_q;
	assign result.hot_active  = flags_q.hot;
	assign result.cold_active = flags_q.cold;
	assign result.rejected    = rejected_q;

	// ---------------------------------------------------------------- checks
	a_wr_only_on_advance: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (valid_s1 && advance && !rejected_s1))
		else $error("flag write-back without a retiring transaction");

	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> valid_s1)
		else $error("accepted transaction lost before compare stage");

	a_rejected_no_event: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && rejected_q) |-> (event_q == EV_NONE))
		else $error("rejected transaction reports an event");

	a_above_sets_hot: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && event_q == EV_ABOVE) |-> (flags_q.hot && !flags_q.cold))
		else $error("hot event without hot flag alone");

	a_below_sets_cold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && event_q == EV_BELOW) |-> (flags_q.cold && !flags_q.hot))
		else $error("cold event without cold flag alone");

endmodule
